// ===== rtl/tpmfm_pkg.sv =====
package tpmfm_pkg;

   // Size of the command and response buffers, in bytes.
   localparam int unsigned BUFFER_BYTES = 4096;
   localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);

   // Register offsets, decoded from the low 12 address bits.
   localparam logic [11:0] REG_STATUS = 12'h018;
   localparam logic [11:0] REG_FIFO   = 12'h024;

   // Status register bits.
   localparam logic [7:0] STS_VALID      = 8'h80;
   localparam logic [7:0] STS_CMD_READY  = 8'h40;
   localparam logic [7:0] STS_GO         = 8'h20;
   localparam logic [7:0] STS_DATA_AVAIL = 8'h10;
   localparam logic [7:0] STS_EXPECT     = 8'h08;
   localparam logic [7:0] STS_RETRY      = 8'h02;
   localparam logic [7:0] STS_RD_MASK    = STS_CMD_READY | STS_DATA_AVAIL | STS_EXPECT;

   // Queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Longest length the result field can show.
   localparam int unsigned LEN_SAT = 8191;
   localparam int unsigned CODE_MIN_LEN = 10;

   typedef enum logic [2:0] {
      TIS_UNKNOWN    = 3'd0,
      TIS_IDLE       = 3'd1,
      TIS_READY      = 3'd2,
      TIS_RECEPTION  = 3'd3,
      TIS_EXECUTION  = 3'd4,
      TIS_COMPLETION = 3'd5
   } state_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_CMD      = 3'd1,
      EV_RSP      = 3'd2,
      EV_MULTI    = 3'd3,
      EV_ABORT_RX = 3'd4,
      EV_GO_IGN   = 3'd5,
      EV_ABORT_EX = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      OP_NONE      = 3'd0,
      OP_STATUS_RD = 3'd1,
      OP_STATUS_WR = 3'd2,
      OP_FIFO_RD   = 3'd3,
      OP_FIFO_WR   = 3'd4
   } op_type;

   typedef struct packed {
      logic        req_type;
      logic [23:0] reg_address;
      logic [7:0]  data_byte;
      logic        first_of_transfer;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  iface_state;
      logic        state_changed;
      logic [2:0]  event_kind;
      logic [12:0] message_length;
      logic [31:0] message_code;
      logic        code_valid;
   } rsp_beat_type;

   // One classified transaction byte, as passed from front to back.
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [31:0]      code;
   } msg_type;

endpackage

// ===== rtl/tpm_tis_fifo_monitor_unit.sv =====
// Path: a beat accepted on req is written into the queue, then popped by the back part,
// which registers its result and presents it on rsp; the pop waits while the result
// register is full and not being drained.
// Throughput: one beat per cycle while the result register is empty or being drained.
// Reset: synchronous, active high; the tracked state returns to unknown and all
// byte counts and captured codes are cleared, with the queue and result register emptied.
module tpm_tis_fifo_monitor_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tpmfm_pkg::req_beat_type req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tpmfm_pkg::rsp_beat_type rsp_beat
);

   // The front part decodes the register offset and direction of each beat
   // into a short operation code. Status beats other than the first of their
   // transfer become no-ops here, so the back never sees them as status traffic.
   tpmfm_pkg::cmd_type front_cmd;
   tpmfm_pkg::cmd_type back_cmd;
   logic               queue_full;
   logic               queue_not_empty;
   logic               back_pop;

   tpmfm_front u_front (
      .req_beat (req_beat),
      .cmd      (front_cmd)
   );

   // The two-entry queue lets the front keep taking beats while the result
   // register waits on the consumer. Ready depends only on the fill level,
   // so there is no combinational path from rsp_ready to req_ready.
   assign req_ready = !queue_full;

   tpmfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_cmd),
      .full      (queue_full),
      .pop       (back_pop),
      .not_empty (queue_not_empty),
      .pop_data  (back_cmd)
   );

   // The back part holds the interface state and the command and response
   // byte counters. It retires one queued beat per cycle whenever its result
   // register is empty or being drained, producing exactly one result per beat.
   tpmfm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (back_cmd),
      .cmd_pop   (back_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

endmodule

// ===== rtl/tpmfm_front.sv =====
module tpmfm_front (
   input  tpmfm_pkg::req_beat_type req_beat,
   output tpmfm_pkg::cmd_type      cmd
);

   logic [11:0] offset;

   assign offset = req_beat.reg_address[11:0];

   // Only the first byte of a status transfer is acted upon; other
   // addresses are passed on as no-ops so every beat still yields a result.
   always_comb begin
      cmd.data = req_beat.data_byte;
      cmd.op   = tpmfm_pkg::OP_NONE;
      if (offset == tpmfm_pkg::REG_STATUS) begin
         if (req_beat.first_of_transfer) begin
            cmd.op = req_beat.req_type ? tpmfm_pkg::OP_STATUS_RD : tpmfm_pkg::OP_STATUS_WR;
         end
      end else if (offset == tpmfm_pkg::REG_FIFO) begin
         cmd.op = req_beat.req_type ? tpmfm_pkg::OP_FIFO_RD : tpmfm_pkg::OP_FIFO_WR;
      end
   end

endmodule

// ===== rtl/tpmfm_queue.sv =====
module tpmfm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpmfm_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output tpmfm_pkg::cmd_type pop_data
);

   tpmfm_pkg::cmd_type                  entry_ff [tpmfm_pkg::QUEUE_DEPTH];
   logic [tpmfm_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tpmfm_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tpmfm_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                                do_push, do_pop;

   assign full      = (count_ff == tpmfm_pkg::QCNT_W'(tpmfm_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tpmfm_pkg::QPTR_W'(tpmfm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + tpmfm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tpmfm_pkg::QPTR_W'(tpmfm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + tpmfm_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + tpmfm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tpmfm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/tpmfm_back.sv =====
module tpmfm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   input  tpmfm_pkg::cmd_type      cmd,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tpmfm_pkg::rsp_beat_type rsp_beat
);

   tpmfm_pkg::state_type    fsm_state_ff, fsm_state_in;
   logic                    finished_ff, finished_in;
   tpmfm_pkg::msg_type      cmd_msg_ff, cmd_msg_in;
   tpmfm_pkg::msg_type      rsp_msg_ff, rsp_msg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tpmfm_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;

   // Adds one byte to a message; bytes 6 to 9 form the big-endian code.
   function automatic tpmfm_pkg::msg_type append(input tpmfm_pkg::msg_type m,
                                                 input logic [7:0] b);
      tpmfm_pkg::msg_type r;
      logic [31:0]        n;
      r = m;
      n = 32'(m.len);
      if (n < 32'(tpmfm_pkg::BUFFER_BYTES)) begin
         if (n == 32'd6) begin
            r.code[31:24] = b;
         end else if (n == 32'd7) begin
            r.code[23:16] = b;
         end else if (n == 32'd8) begin
            r.code[15:8] = b;
         end else if (n == 32'd9) begin
            r.code[7:0] = b;
         end
         r.len = m.len + tpmfm_pkg::LEN_W'(1);
      end
      return r;
   endfunction

   // Entering reception or completion starts a new transfer.
   function automatic logic finished_after(input tpmfm_pkg::state_type cur,
                                           input tpmfm_pkg::state_type ns,
                                           input logic                 tf);
      logic r;
      r = tf;
      if (ns != cur && (ns == tpmfm_pkg::TIS_RECEPTION || ns == tpmfm_pkg::TIS_COMPLETION)) begin
         r = 1'b0;
      end
      return r;
   endfunction

   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_comb begin
      tpmfm_pkg::state_type ns;
      tpmfm_pkg::event_type ev;
      tpmfm_pkg::msg_type   rep;
      logic                 tf;
      logic [7:0]           b;
      logic [31:0]          rep_len32;

      ns  = fsm_state_ff;
      tf  = finished_ff;
      ev  = tpmfm_pkg::EV_NONE;
      rep = '0;
      b   = cmd.data;
      cmd_msg_in = cmd_msg_ff;
      rsp_msg_in = rsp_msg_ff;

      case (cmd.op)
         tpmfm_pkg::OP_STATUS_RD: begin
            // Leaving the unknown state falls through to the new state's rules.
            if (ns == tpmfm_pkg::TIS_UNKNOWN) begin
               if ((b & (tpmfm_pkg::STS_CMD_READY | tpmfm_pkg::STS_DATA_AVAIL)) ==
                   tpmfm_pkg::STS_CMD_READY) begin
                  tf = finished_after(ns, tpmfm_pkg::TIS_READY, tf);
                  ns = tpmfm_pkg::TIS_READY;
               end else if ((b & tpmfm_pkg::STS_EXPECT) != '0) begin
                  tf = finished_after(ns, tpmfm_pkg::TIS_RECEPTION, tf);
                  ns = tpmfm_pkg::TIS_RECEPTION;
               end else if ((b & tpmfm_pkg::STS_DATA_AVAIL) != '0) begin
                  tf = finished_after(ns, tpmfm_pkg::TIS_COMPLETION, tf);
                  ns = tpmfm_pkg::TIS_COMPLETION;
               end
            end
            case (ns)
               tpmfm_pkg::TIS_IDLE: begin
                  if ((b & (tpmfm_pkg::STS_CMD_READY | tpmfm_pkg::STS_DATA_AVAIL)) ==
                      tpmfm_pkg::STS_CMD_READY) begin
                     ns = tpmfm_pkg::TIS_READY;
                  end else if ((b & tpmfm_pkg::STS_RD_MASK) != '0) begin
                     ns = tpmfm_pkg::TIS_UNKNOWN;
                  end
               end
               tpmfm_pkg::TIS_READY: begin
                  if ((b & tpmfm_pkg::STS_RD_MASK) == tpmfm_pkg::STS_EXPECT) begin
                     tf = finished_after(ns, tpmfm_pkg::TIS_RECEPTION, tf);
                     ns = tpmfm_pkg::TIS_RECEPTION;
                  end else if ((b & (tpmfm_pkg::STS_CMD_READY | tpmfm_pkg::STS_DATA_AVAIL)) !=
                               tpmfm_pkg::STS_CMD_READY) begin
                     ns = tpmfm_pkg::TIS_UNKNOWN;
                  end
               end
               tpmfm_pkg::TIS_RECEPTION: begin
                  if ((b & tpmfm_pkg::STS_VALID) != '0 && (b & tpmfm_pkg::STS_EXPECT) == '0) begin
                     tf = 1'b1;
                  end
               end
               tpmfm_pkg::TIS_EXECUTION: begin
                  if ((b & tpmfm_pkg::STS_RD_MASK) == tpmfm_pkg::STS_DATA_AVAIL) begin
                     rsp_msg_in = '0;
                     tf = finished_after(ns, tpmfm_pkg::TIS_COMPLETION, tf);
                     ns = tpmfm_pkg::TIS_COMPLETION;
                  end else if ((b & tpmfm_pkg::STS_RD_MASK) != '0) begin
                     ns = tpmfm_pkg::TIS_UNKNOWN;
                  end
               end
               tpmfm_pkg::TIS_COMPLETION: begin
                  if ((b & tpmfm_pkg::STS_RD_MASK) == '0) begin
                     rep = rsp_msg_in;
                     tf = 1'b1;
                     rsp_msg_in = '0;
                     ns = tpmfm_pkg::TIS_IDLE;
                     ev = tpmfm_pkg::EV_RSP;
                  end else if ((b & tpmfm_pkg::STS_VALID) != '0 &&
                               (b & tpmfm_pkg::STS_RD_MASK) != tpmfm_pkg::STS_DATA_AVAIL) begin
                     ns = tpmfm_pkg::TIS_UNKNOWN;
                  end
               end
               default: begin
               end
            endcase
         end
         tpmfm_pkg::OP_STATUS_WR: begin
            if (b == '0 || (b & (b - 8'd1)) != '0) begin
               ns = tpmfm_pkg::TIS_UNKNOWN;
               ev = tpmfm_pkg::EV_MULTI;
            end else begin
               case (ns)
                  tpmfm_pkg::TIS_IDLE: begin
                     if ((b & tpmfm_pkg::STS_CMD_READY) != '0) begin
                        ns = tpmfm_pkg::TIS_READY;
                     end
                  end
                  tpmfm_pkg::TIS_RECEPTION: begin
                     if ((b & tpmfm_pkg::STS_CMD_READY) != '0) begin
                        cmd_msg_in = '0;
                        ns = tpmfm_pkg::TIS_IDLE;
                        ev = tpmfm_pkg::EV_ABORT_RX;
                     end else if ((b & tpmfm_pkg::STS_GO) != '0) begin
                        if (!tf) begin
                           ev = tpmfm_pkg::EV_GO_IGN;
                        end else begin
                           rep = cmd_msg_ff;
                           cmd_msg_in = '0;
                           ns = tpmfm_pkg::TIS_EXECUTION;
                           ev = tpmfm_pkg::EV_CMD;
                        end
                     end
                  end
                  tpmfm_pkg::TIS_EXECUTION: begin
                     if ((b & tpmfm_pkg::STS_CMD_READY) != '0) begin
                        ns = tpmfm_pkg::TIS_IDLE;
                        ev = tpmfm_pkg::EV_ABORT_EX;
                     end
                  end
                  tpmfm_pkg::TIS_COMPLETION: begin
                     if ((b & tpmfm_pkg::STS_RETRY) != '0) begin
                        rsp_msg_in = '0;
                     end else if ((b & tpmfm_pkg::STS_CMD_READY) != '0) begin
                        rsp_msg_in = '0;
                        ns = tpmfm_pkg::TIS_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tpmfm_pkg::OP_FIFO_RD: begin
            if (ns == tpmfm_pkg::TIS_COMPLETION && !tf) begin
               rsp_msg_in = append(rsp_msg_ff, b);
            end
         end
         tpmfm_pkg::OP_FIFO_WR: begin
            if (ns == tpmfm_pkg::TIS_READY || ns == tpmfm_pkg::TIS_IDLE) begin
               cmd_msg_in = append('0, b);
               tf = finished_after(ns, tpmfm_pkg::TIS_RECEPTION, tf);
               ns = tpmfm_pkg::TIS_RECEPTION;
            end else if (ns == tpmfm_pkg::TIS_RECEPTION && !tf) begin
               cmd_msg_in = append(cmd_msg_ff, b);
            end
         end
         default: begin
         end
      endcase

      fsm_state_in = ns;
      finished_in  = tf;

      rep_len32 = 32'(rep.len);
      rsp_beat_in.iface_state    = ns;
      rsp_beat_in.state_changed  = (ns != fsm_state_ff);
      rsp_beat_in.event_kind     = ev;
      rsp_beat_in.message_length = '0;
      rsp_beat_in.message_code   = '0;
      rsp_beat_in.code_valid     = 1'b0;
      if (ev == tpmfm_pkg::EV_CMD || ev == tpmfm_pkg::EV_RSP) begin
         rsp_beat_in.message_length = (rep_len32 > 32'(tpmfm_pkg::LEN_SAT)) ?
                                      13'(tpmfm_pkg::LEN_SAT) : rep_len32[12:0];
         rsp_beat_in.code_valid     = (rep_len32 >= 32'(tpmfm_pkg::CODE_MIN_LEN));
         rsp_beat_in.message_code   = rsp_beat_in.code_valid ? rep.code : '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_state_ff <= tpmfm_pkg::TIS_UNKNOWN;
         finished_ff  <= 1'b0;
         cmd_msg_ff   <= '0;
         rsp_msg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd_pop) begin
            fsm_state_ff <= fsm_state_in;
            finished_ff  <= finished_in;
            cmd_msg_ff   <= cmd_msg_in;
            rsp_msg_ff   <= rsp_msg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

endmodule
